>>> src/ctr_pkg.sv
package ctr_pkg;

  // Compact target encoding: exponent byte over a 24-bit mantissa
  localparam int WORD_W = 32;
  localparam int EXPO_W = 8;
  localparam int MANT_W = 24;

  // Scaled mantissa is below 2^32 * 4 * interval / interval, so 34 bits
  localparam int QUO_W  = 34;

  // Reset value of the maximum target register
  localparam logic [WORD_W-1:0] MAX_TARGET_RST = 32'h1D00FFFF;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [EXPO_W-1:0] expo_t;
  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [QUO_W-1:0]  quo_t;

endpackage

>>> src/compact_target_retarget_top.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------------
// request  | in_old_target, in_elapsed_time          | taken when start && !busy
// result   | out_new_target                          | out_valid, one cycle, no stall
// config   | cfg_wdata                               | written when cfg_we
//
// One request may be taken every cycle. Its result is strobed once it has passed
// the input, clamp, product, quotient estimate, remainder, quotient fix-up and
// result registers. The divide by TARGET_INTERVAL is a reciprocal multiply; its
// estimate is at most two low and is fixed up from the remainder.
// Reset is synchronous and active low; busy is high only while reset is held.
module compact_target_retarget_top #(
  parameter int TARGET_INTERVAL = 1209600
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           in_old_target,
  input  logic [31:0]           in_elapsed_time,
  output logic                  out_valid,
  output logic [31:0]           out_new_target,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata
);

  localparam int QW  = ctr_pkg::QUO_W;
  // Log2 of the largest power of two not above the interval
  localparam int KS  = $clog2(TARGET_INTERVAL + 1) - 1;
  // Clamped time fits TW bits, so the product fits NW bits
  localparam int TW  = $clog2(longint'(TARGET_INTERVAL) * 4 + 1);
  localparam int NW  = ctr_pkg::WORD_W + TW;
  localparam int HW  = NW - KS;
  // Remainder after the estimate stays below three intervals
  localparam int RMW = KS + 3;
  localparam int LAT = 7;
  localparam logic [31:0] T_LO = 32'(longint'(TARGET_INTERVAL) / 4);
  localparam logic [31:0] T_HI = 32'(longint'(TARGET_INTERVAL) * 4);
  localparam longint unsigned N_ONES = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NW);
  localparam logic [HW-1:0]  RECIP  = HW'(N_ONES / 64'(TARGET_INTERVAL));
  localparam logic [RMW-1:0] DIV_R  = RMW'(TARGET_INTERVAL);
  localparam logic [RMW-1:0] DIV_R2 = RMW'(longint'(TARGET_INTERVAL) * 2);

  ctr_pkg::word_t max_target_r;

  logic           in_vld_r;
  ctr_pkg::word_t in_old_r;
  ctr_pkg::word_t in_time_r;

  logic           cl_vld_r;
  ctr_pkg::word_t cl_mant_r;
  ctr_pkg::word_t cl_time_r;
  ctr_pkg::expo_t cl_expo_r;
  ctr_pkg::word_t time_nxt;

  logic [63:0]    prod;

  logic           pr_vld_r;
  logic [NW-1:0]  pr_n_r;
  ctr_pkg::expo_t pr_expo_r;

  logic [HW+QW-1:0] est;
  logic             es_vld_r;
  ctr_pkg::quo_t    es_q_r;
  logic [RMW-1:0]   es_nlo_r;
  ctr_pkg::expo_t   es_expo_r;

  logic [RMW-1:0]   qd_lo;
  logic             rm_vld_r;
  ctr_pkg::quo_t    rm_q_r;
  logic [RMW-1:0]   rm_rem_r;
  ctr_pkg::expo_t   rm_expo_r;

  ctr_pkg::quo_t    q_nxt;
  logic             qt_vld_r;
  ctr_pkg::quo_t    qt_q_r;
  ctr_pkg::expo_t   qt_expo_r;

  ctr_pkg::quo_t  quo;
  ctr_pkg::mant_t mant_a;
  ctr_pkg::expo_t expo_a;
  ctr_pkg::mant_t mant_b;
  ctr_pkg::expo_t expo_b;
  ctr_pkg::word_t word_nxt;

  logic           out_valid_r;
  ctr_pkg::word_t out_new_target_r;

  logic           accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_target_r <= ctr_pkg::MAX_TARGET_RST;
    end else if (cfg_we) begin
      max_target_r <= cfg_wdata;
    end
  end

  // Valid flags along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      cl_vld_r    <= 1'b0;
      pr_vld_r    <= 1'b0;
      es_vld_r    <= 1'b0;
      rm_vld_r    <= 1'b0;
      qt_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_vld_r    <= accept;
      cl_vld_r    <= in_vld_r;
      pr_vld_r    <= cl_vld_r;
      es_vld_r    <= pr_vld_r;
      rm_vld_r    <= es_vld_r;
      qt_vld_r    <= rm_vld_r;
      out_valid_r <= qt_vld_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      in_old_r  <= in_old_target;
      in_time_r <= in_elapsed_time;
    end
  end

  // Clamp elapsed time to a quarter .. four times the interval
  always_comb begin
    time_nxt = in_time_r;
    if (in_time_r < T_LO) begin
      time_nxt = T_LO;
    end
    if (in_time_r > T_HI) begin
      time_nxt = T_HI;
    end
  end

  always_ff @(posedge clk) begin
    cl_mant_r <= {in_old_r[ctr_pkg::MANT_W-1:0], 8'h00};
    cl_time_r <= time_nxt;
    cl_expo_r <= in_old_r[ctr_pkg::WORD_W-1 -: ctr_pkg::EXPO_W];
  end

  // Scale: 32x32 product
  assign prod = cl_mant_r * cl_time_r;

  always_ff @(posedge clk) begin
    pr_n_r    <= prod[NW-1:0];
    pr_expo_r <= cl_expo_r;
  end

  // Quotient estimate from the top product bits times the reciprocal
  assign est = pr_n_r[NW-1:KS] * RECIP;

  always_ff @(posedge clk) begin
    es_q_r    <= est[HW +: QW];
    es_nlo_r  <= pr_n_r[RMW-1:0];
    es_expo_r <= pr_expo_r;
  end

  // Remainder of the estimate; only its low bits are needed
  assign qd_lo = es_q_r[RMW-1:0] * DIV_R;

  always_ff @(posedge clk) begin
    rm_q_r    <= es_q_r;
    rm_rem_r  <= es_nlo_r - qd_lo;
    rm_expo_r <= es_expo_r;
  end

  // Fix-up: estimate is zero, one or two below the exact quotient
  always_comb begin
    q_nxt = rm_q_r;
    if (rm_rem_r >= DIV_R2) begin
      q_nxt = rm_q_r + QW'(2);
    end else if (rm_rem_r >= DIV_R) begin
      q_nxt = rm_q_r + QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    qt_q_r    <= q_nxt;
    qt_expo_r <= rm_expo_r;
  end

  assign quo = qt_q_r;

  // Renormalize into compact form and clamp to the maximum target
  always_comb begin
    if (quo[QW-1:32] != '0) begin
      mant_a = ctr_pkg::MANT_W'(quo[QW-1:16]);
      expo_a = qt_expo_r + 8'd1;
    end else if (quo[31:24] != '0) begin
      mant_a = quo[31:8];
      expo_a = qt_expo_r;
    end else begin
      mant_a = quo[23:0];
      expo_a = qt_expo_r - 8'd1;
    end

    // Top mantissa bit set: one more byte down
    if (mant_a[ctr_pkg::MANT_W-1]) begin
      mant_b = {8'h00, mant_a[ctr_pkg::MANT_W-1:8]};
      expo_b = expo_a + 8'd1;
    end else begin
      mant_b = mant_a;
      expo_b = expo_a;
    end

    word_nxt = {expo_b, mant_b};
    if (word_nxt > max_target_r) begin
      word_nxt = max_target_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    out_new_target_r <= word_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_new_target = out_new_target_r;

  // Every taken request gives exactly one result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, LAT))
    else $error("result strobe does not match request latency");

  // A delivered result never exceeds the maximum target
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_target <= max_target_r))
    else $error("result above maximum target");

  // Unless clamped, the mantissa top bit is always clear
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_new_target != max_target_r)) |-> !out_new_target[23])
    else $error("result mantissa has top bit set");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam ctr_pkg::word_t INTERVAL = 32'd1209600;
  localparam ctr_pkg::word_t TIME_LO  = INTERVAL / 4;
  localparam ctr_pkg::word_t TIME_HI  = INTERVAL * 4;
  localparam int LATENCY      = 7;
  localparam int LIMIT_CYCLES = 400000;
  localparam ctr_pkg::word_t CAP_OPEN = 32'hFFFFFFFF;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  ctr_pkg::word_t in_old_target = '0;
  ctr_pkg::word_t in_elapsed_time = '0;
  logic  out_valid;
  ctr_pkg::word_t out_new_target;
  logic  cfg_we = 1'b0;
  ctr_pkg::word_t cfg_wdata = '0;

  // Testbench copy of the max target register
  ctr_pkg::word_t cap_shadow = ctr_pkg::MAX_TARGET_RST;
  // New targets still owed by the pipeline, oldest first
  ctr_pkg::word_t target_q[$];
  int    idle_pct = 0;
  int    errors = 0;
  int    cycles = 0;

  compact_target_retarget_top #(.TARGET_INTERVAL(int'(INTERVAL))) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_old_target   (in_old_target),
    .in_elapsed_time (in_elapsed_time),
    .out_valid       (out_valid),
    .out_new_target  (out_new_target),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Retarget: clamp time, scale mantissa, renormalize, clamp to cap
  function automatic ctr_pkg::word_t calc_new_target(ctr_pkg::word_t old_t,
                                                     ctr_pkg::word_t elapsed,
                                                     ctr_pkg::word_t cap);
    logic [63:0]    span;
    logic [63:0]    scaled;
    ctr_pkg::expo_t expo;
    ctr_pkg::word_t word;
    span = 64'(elapsed);
    if (span < 64'(TIME_LO)) span = 64'(TIME_LO);
    if (span > 64'(TIME_HI)) span = 64'(TIME_HI);
    scaled = 64'(old_t[23:0]) << 8;
    scaled = (scaled * span) / 64'(INTERVAL);
    expo = old_t[31:24];
    if (scaled[35:32] != 4'h0) begin
      // mantissa overflow: drop two bytes, exponent up
      scaled = (scaled >> 16) & 64'hFFFFFF;
      expo = expo + 8'd1;
    end else if (scaled[31:24] != 8'h0) begin
      scaled = scaled >> 8;
    end else begin
      expo = expo - 8'd1;
    end
    // top mantissa bit is the sign: push one more byte down
    if (scaled > 64'h7FFFFF) begin
      scaled = scaled >> 8;
      expo = expo + 8'd1;
    end
    word = {expo, scaled[23:0]};
    return (word > cap) ? cap : word;
  endfunction

  task automatic report_mismatch(string what, ctr_pkg::word_t got, ctr_pkg::word_t want);
    $display("[%0t] mismatch %s: got %08h want %08h", $time, what, got, want);
    errors++;
  endtask

  // Result checker: one strobe per result, no back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (target_q.size() == 0) begin
        report_mismatch("unexpected result", out_new_target, '0);
      end else begin
        if (out_new_target !== target_q[0])
          report_mismatch("new_target", out_new_target, target_q[0]);
        void'(target_q.pop_front());
      end
    end
  end

  // Send one request, then maybe leave the request line idle for a while
  task automatic send_request(ctr_pkg::word_t old_t, ctr_pkg::word_t elapsed);
    int gap;
    start <= 1'b1;
    in_old_target <= old_t;
    in_elapsed_time <= elapsed;
    @(posedge clk);
    while (busy) @(posedge clk);
    target_q.push_back(calc_new_target(old_t, elapsed, cap_shadow));
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(45, 5) : $urandom_range(4, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    if (start) start <= 1'b0;
    while (target_q.size() != 0) @(posedge clk);
  endtask

  // Cap register is only written with the pipeline empty
  task automatic write_max_target(ctr_pkg::word_t value);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_shadow = value;
  endtask

  task automatic send_random_request();
    ctr_pkg::word_t mant;
    ctr_pkg::word_t elapsed;
    case ($urandom_range(4))
      0: mant = $urandom_range(24'hFFFFFF);
      1: mant = $urandom_range(16'hFFFF);
      2: mant = $urandom_range(24'hFFFFFF, 24'h7F0000);
      3: mant = $urandom_range(8'hFF);
      default: mant = $urandom_range(1) ? 32'hFFFFFF : 32'h0;
    endcase
    case ($urandom_range(5))
      0: elapsed = $urandom();
      1: elapsed = $urandom_range(TIME_HI * 2, TIME_LO / 2);
      2: elapsed = $urandom_range(TIME_HI, TIME_LO);
      3: elapsed = TIME_LO + $urandom_range(4) - 2;
      4: elapsed = TIME_HI + $urandom_range(4) - 2;
      default: elapsed = $urandom_range(1) ? 32'hFFFFFFFF - $urandom_range(255)
                                           : $urandom_range(TIME_LO);
    endcase
    send_request({8'($urandom_range(255)), mant[23:0]}, elapsed);
  endtask

  task automatic pick_random_cap();
    case ($urandom_range(3))
      0: write_max_target(CAP_OPEN);
      1: write_max_target($urandom());
      2: write_max_target({8'($urandom_range(255)), 24'hFFFFFF});
      default: write_max_target(ctr_pkg::MAX_TARGET_RST);
    endcase
  endtask

  task automatic run_random_batches(int count);
    int b;
    int i;
    for (b = 0; b < 3; b++) begin
      pick_random_cap();
      for (i = 0; i < count / 3; i++) send_random_request();
    end
  endtask

  // Reset value of the cap is in force before any write
  task automatic test_default_cap();
    idle_pct = 0;
    send_request(32'h1D00FFFF, INTERVAL);
    send_request(32'h1D00FFFF, TIME_HI);
    send_request(32'h1C7FFFFF, TIME_LO);
  endtask

  // Each renormalize path, exponent wrap, time clamp edges
  task automatic test_special_cases();
    write_max_target(CAP_OPEN);
    send_request(32'h20FFFFFF, TIME_HI);          // mantissa overflow
    send_request(32'hFFFFFFFF, 32'hFFFFFFFF);     // overflow, exponent wraps up
    send_request(32'h1B123456, INTERVAL);         // same byte range
    send_request(32'h1B800000, INTERVAL);         // same byte range, sign bit
    send_request(32'h1C00ABCD, INTERVAL);         // underflow
    send_request(32'h1C00FFFF, INTERVAL);         // underflow, sign bit
    send_request(32'h00000000, 32'h0);            // zero mantissa, exponent wraps down
    send_request(32'h05000000, INTERVAL);
    send_request(32'h00000001, TIME_LO);
    send_request(32'h1A7FFFFF, TIME_LO - 1);
    send_request(32'h1A7FFFFF, TIME_LO);
    send_request(32'h1A7FFFFF, TIME_HI);
    send_request(32'h1A7FFFFF, TIME_HI + 1);
    send_request(32'hFFFFFFFF, 32'h0);
  endtask

  task automatic test_cap_extremes();
    write_max_target(32'h0);
    send_request(32'h1D00FFFF, INTERVAL);
    send_request(32'h00000000, 32'h0);
    write_max_target(32'h12345678);
    send_request(32'h12345678, INTERVAL);
    send_request(32'h12FFFFFF, TIME_HI);
  endtask

  task automatic test_random_no_idle();
    idle_pct = 0;
    run_random_batches(650);
  endtask

  task automatic test_random_sender_idle();
    idle_pct = 69;
    run_random_batches(650);
  endtask

  task automatic test_random_both_idle();
    idle_pct = 36;
    run_random_batches(650);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_default_cap();
    test_special_cases();
    test_cap_extremes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_both_idle();
    drain_pipeline();
    // catch any stray strobes
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> compact_target_retarget_top.f
src/ctr_pkg.sv
src/compact_target_retarget_top.sv
tb/sv/tb_top.sv
